>>> hdl/swas_pkg.sv
// Shared types and constants for the sliding-window anagram search block.
package swas_pkg;

	localparam int unsigned MAX_PATTERN_DEF = 64;
	localparam int unsigned ALPHABET_DEF    = 256;

	localparam int unsigned OP_W      = 2;
	localparam int unsigned SYMBOL_W  = 8;
	localparam int unsigned COUNT_W   = 32;
	localparam int unsigned S_TDATA_W = 16;
	localparam int unsigned RES_W     = 1 + 2 * COUNT_W;
	localparam int unsigned M_TDATA_W = 72;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR   = 2'd0,
		OP_PATTERN = 2'd1,
		OP_TEXT    = 2'd2
	} op_t;

	// One result item, packed with match in the lowest bit.
	typedef struct packed {
		logic [COUNT_W-1:0] match_count;
		logic [COUNT_W-1:0] window_start;
		logic               match;
	} res_t;

endpackage

>>> hdl/sliding_window_anagram_search.sv
// Top level of the streaming sliding-window anagram search.
//
// The block takes a stream of items, each an operation and a byte symbol.
// A clear item empties the per-symbol balance table and restarts all
// counters; pattern items add one to their symbol's balance and lengthen
// the pattern up to MAX_PATTERN bytes (later pattern bytes are dropped);
// text items subtract one from their symbol's balance and enter a window
// delay line. Once the window holds as many text bytes as the pattern, every
// text item gives one result item: a match flag (the window is a
// permutation of the pattern), the text position of the window's first
// byte, and a saturating count of matching windows since the last clear.
// Text that arrives before any pattern byte is dropped silently, and the
// unused operation code is ignored. Every item keeps the block busy after
// it is accepted, so no new item is taken while busy: the balance table
// is one memory with one read and one write port, and a text item that
// completes a window needs two read-modify-write passes through it, one for
// the incoming symbol and one for the symbol that leaves the window. A result
// passes through the registered balance read stage and is then written into
// the output queue, from which it is presented on the output.
// Results wait in a two-entry output queue, so a stalled consumer does not
// hold back input until that queue is full. The balance table needs no
// clearing pass: a valid flag per entry, cleared at reset and by a clear
// item, makes unwritten entries read as zero.
module sliding_window_anagram_search #(
	parameter int unsigned MAX_PATTERN = swas_pkg::MAX_PATTERN_DEF,
	parameter int unsigned ALPHABET    = swas_pkg::ALPHABET_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// Fields from bit 0 up: operation[1:0], symbol[9:2], zero padding.
	input  logic [swas_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// Fields from bit 0 up: match[0], window_start[32:1],
	// match_count[64:33], zero padding.
	output logic [swas_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int unsigned SYM_W = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int unsigned PL_W  = $clog2(MAX_PATTERN + 1);
	localparam int unsigned BAL_W = PL_W + 1;
	localparam int unsigned WP_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int unsigned UM_W  = $clog2(ALPHABET + 1);
	localparam int unsigned CW    = swas_pkg::COUNT_W;
	localparam int unsigned NSYM  = 2 ** swas_pkg::SYMBOL_W;

	// Symbol reduction table: the byte value modulo the alphabet size.
	logic [SYM_W-1:0] sym_mod_tab [NSYM];
	for (genvar i = 0; i < NSYM; i++) begin : g_sym_mod
		localparam int unsigned SYM_RED = i % ALPHABET;
		assign sym_mod_tab[i] = SYM_W'(SYM_RED);
	end

	// Input decode.
	swas_pkg::op_t               in_op;
	logic [swas_pkg::SYMBOL_W-1:0] in_sym_raw;
	logic [SYM_W-1:0]            in_sym;
	logic                        acc;
	logic                        acc_clr;
	logic                        acc_pat;
	logic                        acc_txt;

	// Control state.
	logic            busy_q;
	logic [PL_W-1:0] pl_q;
	logic [PL_W-1:0] fill_q;
	logic [WP_W-1:0] wp_q;
	logic [CW-1:0]   tpos_q;
	logic [CW-1:0]   matches_q;
	logic [UM_W-1:0] um_q;
	logic [ALPHABET-1:0] bal_vld_q;

	// Window delay line.
	logic [SYM_W-1:0] win_mem [MAX_PATTERN];
	logic [SYM_W-1:0] win_rd_s1;
	logic [SYM_W-1:0] sym_s1;
	logic             win_fwd_s1;
	logic             drop_s1;
	logic [PL_W-1:0]  fill_inc;
	logic             win_full;
	logic [WP_W-1:0]  pl_m1;
	logic [WP_W:0]    old_diff;
	logic [WP_W-1:0]  old_idx;
	logic [WP_W-1:0]  wp_next;
	logic [SYM_W-1:0] old_sym;
	logic [CW-1:0]    ws_now;

	// Balance table and its read-modify-write pipeline.
	logic [BAL_W-1:0] bal_mem [ALPHABET];
	logic             req_v;
	logic [SYM_W-1:0] req_addr;
	logic             req_inc;
	logic             req_res;
	logic             bop_v_s1;
	logic [SYM_W-1:0] bop_addr_s1;
	logic             bop_inc_s1;
	logic             bop_res_s1;
	logic [CW-1:0]    ws_s1;
	logic [BAL_W-1:0] bal_rd_s1;
	logic             bal_vld_s1;
	logic             fwd_hit_s1;
	logic [BAL_W-1:0] fwd_data_s1;
	logic [BAL_W-1:0] bal_cur;
	logic [BAL_W-1:0] bal_new;
	logic [UM_W-1:0]  um_next;
	logic             res_push;
	logic             hit;
	logic [CW-1:0]    cnt_next;

	// Output queue.
	swas_pkg::res_t fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           res_pop;

	assign in_op      = swas_pkg::op_t'(s_tdata[swas_pkg::OP_W-1:0]);
	assign in_sym_raw = s_tdata[swas_pkg::OP_W +: swas_pkg::SYMBOL_W];
	assign in_sym     = sym_mod_tab[in_sym_raw];

	// An accepted item holds the block busy for its second pass; the queue must
	// have room for the result that this item may produce.
	assign s_tready = !busy_q && (count_q != 2'd2);
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		acc_clr = 1'b0;
		acc_pat = 1'b0;
		acc_txt = 1'b0;
		case (in_op)
			swas_pkg::OP_CLEAR:   acc_clr = acc;
			swas_pkg::OP_PATTERN: acc_pat = acc && (pl_q < PL_W'(MAX_PATTERN));
			swas_pkg::OP_TEXT:    acc_txt = acc && (pl_q != '0);
			default:              acc_clr = 1'b0;
		endcase
	end

	// Window bookkeeping for the incoming text byte.
	assign fill_inc = fill_q + PL_W'(1);
	assign win_full = (fill_inc >= pl_q);
	assign pl_m1    = WP_W'(pl_q - PL_W'(1));
	assign old_diff = {1'b0, wp_q} - {1'b0, pl_m1};
	assign old_idx  = old_diff[WP_W] ? WP_W'(old_diff + (WP_W + 1)'(MAX_PATTERN))
	                                 : old_diff[WP_W-1:0];
	assign wp_next  = (wp_q == WP_W'(MAX_PATTERN - 1)) ? '0 : wp_q + WP_W'(1);
	assign ws_now   = tpos_q - CW'(pl_q) + CW'(1);

	// With a one-byte pattern the oldest entry is the one written this cycle.
	assign old_sym = win_fwd_s1 ? sym_s1 : win_rd_s1;

	always_ff @(posedge clk) begin
		if (acc_txt) begin
			win_mem[wp_q] <= in_sym;
			win_rd_s1     <= win_mem[old_idx];
			win_fwd_s1    <= (old_idx == wp_q);
			sym_s1        <= in_sym;
		end
	end

	// While idle, an accepted pattern or text item issues its own balance update;
	// while busy, the block issues the restore of a byte that leaves a full window.
	always_comb begin
		if (busy_q) begin
			req_v    = drop_s1;
			req_addr = old_sym;
			req_inc  = 1'b1;
			req_res  = 1'b0;
		end else begin
			req_v    = acc_pat || acc_txt;
			req_addr = in_sym;
			req_inc  = acc_pat;
			req_res  = acc_txt && win_full;
		end
	end

	// Read data is either the registered memory word, the word written in
	// the cycle of the read, or zero for an entry not written since clear.
	assign bal_cur = fwd_hit_s1 ? fwd_data_s1 : (bal_vld_s1 ? bal_rd_s1 : '0);
	assign bal_new = bop_inc_s1 ? bal_cur + BAL_W'(1) : bal_cur - BAL_W'(1);

	always_comb begin
		um_next = um_q;
		if ((bal_cur == '0) && (bal_new != '0)) begin
			um_next = um_q + UM_W'(1);
		end else if ((bal_cur != '0) && (bal_new == '0)) begin
			um_next = um_q - UM_W'(1);
		end
	end

	assign res_push = bop_v_s1 && bop_res_s1;
	assign hit      = (um_next == '0);
	assign cnt_next = (hit && (matches_q != '1)) ? matches_q + CW'(1) : matches_q;

	always_ff @(posedge clk) begin
		if (bop_v_s1) begin
			bal_mem[bop_addr_s1] <= bal_new;
		end
		if (req_v) begin
			bal_rd_s1   <= bal_mem[req_addr];
			bal_vld_s1  <= bal_vld_q[req_addr];
			fwd_hit_s1  <= bop_v_s1 && (bop_addr_s1 == req_addr);
			fwd_data_s1 <= bal_new;
			bop_addr_s1 <= req_addr;
			bop_inc_s1  <= req_inc;
			bop_res_s1  <= req_res;
			ws_s1       <= ws_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			drop_s1   <= 1'b0;
			bop_v_s1  <= 1'b0;
			pl_q      <= '0;
			fill_q    <= '0;
			wp_q      <= '0;
			tpos_q    <= '0;
			matches_q <= '0;
			um_q      <= '0;
			bal_vld_q <= '0;
		end else begin
			busy_q   <= acc;
			drop_s1  <= acc_txt && win_full;
			bop_v_s1 <= req_v;
			// A clear takes priority over the updates of the last write of the item before it.
			if (acc_clr) begin
				pl_q      <= '0;
				fill_q    <= '0;
				wp_q      <= '0;
				tpos_q    <= '0;
				matches_q <= '0;
				um_q      <= '0;
				bal_vld_q <= '0;
			end else begin
				if (bop_v_s1) begin
					bal_vld_q[bop_addr_s1] <= 1'b1;
					um_q                   <= um_next;
				end
				if (res_push) begin
					matches_q <= cnt_next;
				end
				if (acc_pat) begin
					pl_q <= pl_q + PL_W'(1);
				end
				if (acc_txt) begin
					if (!win_full) begin
						fill_q <= fill_inc;
					end
					wp_q   <= wp_next;
					tpos_q <= tpos_q + CW'(1);
				end
			end
		end
	end

	// Two-entry result queue.
	assign m_tvalid = (count_q != 2'd0);
	assign res_pop  = m_tvalid && m_tready;
	assign m_tdata  = {{(swas_pkg::M_TDATA_W - swas_pkg::RES_W){1'b0}}, fifo_q[rd_ptr_q]};

	always_ff @(posedge clk) begin
		if (res_push) begin
			fifo_q[wr_ptr_q] <= '{match_count: cnt_next, window_start: ws_s1, match: hit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (res_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (res_push && !res_pop) begin
				count_q <= count_q + 2'd1;
			end else if (res_pop && !res_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> hdl/swas_checker.sv
// Port-level assertions for the anagram search block and their binding.
module swas_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [swas_pkg::S_TDATA_W-1:0] s_tdata,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [swas_pkg::M_TDATA_W-1:0] m_tdata
);

	// An accepted item sets the busy state, in which no input is taken.
	a_two_cycle_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken in the cycle after an accepted item");

	// A waiting result holds still until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

	// A result into an empty queue comes from an earlier accepted text item.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready &&
		(s_tdata[1:0] == swas_pkg::OP_TEXT), 2))
		else $error("result without a text item");

	// A matching window has always been counted.
	a_match_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[64:33] != 32'd0)
		else $error("match reported with a zero match count");

endmodule

bind sliding_window_anagram_search swas_checker u_swas_checker (.*);
